// ----- hw/rtl/sorted_priority_list_with_city_extract_assert.svh -----
// ----------------------------------------------------------------------------
// sorted priority list assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_LIST_WITH_CITY_EXTRACT_ASSERT_SVH
`define SORTED_PRIORITY_LIST_WITH_CITY_EXTRACT_ASSERT_SVH

`ifndef SYNTHESIS

`define SPLCE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("splce assertion failed");

`define SPLCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("splce assertion failed");

`else

`define SPLCE_ASSERT(lbl, clk, rstn, prop)

`define SPLCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/splce_pkg.sv -----
// ----------------------------------------------------------------------------
// sorted priority list package
// sizes, codes, entry type and ordering rule
// ----------------------------------------------------------------------------
`default_nettype none

package splce_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 31;
    localparam int CODE_W      = 8;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        KIND_INSERTED  = 2'd0,
        KIND_FULL      = 2'd1,
        KIND_EXTRACTED = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_INS  = 2'd1,
        ST_EXT  = 2'd2,
        ST_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] city;
        logic [CODE_W-1:0] zone;
        logic              night;
    } t_entry;

    // true when a must stand before b
    function automatic logic goes_before(input t_entry a, input t_entry b);
        logic res;
        if (a.night == b.night) begin
            res = (a.id < b.id);
        end else begin
            res = a.night;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_priority_list_with_city_extract.sv -----
// insert walks down from the table end and stops at its slot; a full table rejects it
// extract scans every entry to its last result, and any output stall holds it
// a rejected insert skips the walk; one item is worked at a time
// ready returns the cycle after the last result is loaded; the walk uses the single read/compare port
// reset (synchronous, active low) empties the table and drops any pending result
// ----------------------------------------------------------------------------
// sorted priority list with city extract
// ordered parcel table with sequential insert and per-city extraction
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_list_with_city_extract (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_cmd,
    input  wire  [splce_pkg::ID_W-1:0]   i_parcel_id,
    input  wire  [splce_pkg::CODE_W-1:0] i_city_code,
    input  wire  [splce_pkg::CODE_W-1:0] i_zone_code,
    input  wire                          i_overnight,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_kind,
    output logic [splce_pkg::ID_W-1:0]   o_out_id,
    output logic [splce_pkg::CODE_W-1:0] o_out_city,
    output logic [splce_pkg::CODE_W-1:0] o_out_zone,
    output logic                         o_out_overnight,
    output logic                         o_last
);

    `include "sorted_priority_list_with_city_extract_assert.svh"

    splce_pkg::t_entry                   r_mem [splce_pkg::TABLE_DEPTH];

    splce_pkg::t_state                   r_state, n_state;
    logic [splce_pkg::CNT_W-1:0]         r_count, n_count;
    logic [splce_pkg::CNT_W-1:0]         r_idx, n_idx;
    logic [splce_pkg::CNT_W-1:0]         r_keep, n_keep;
    logic [splce_pkg::CODE_W-1:0]        r_key, n_key;
    splce_pkg::t_entry                   r_res, n_res;
    splce_pkg::t_kind                    r_kind, n_kind;
    logic                                r_pend, n_pend;

    logic                                r_out_valid;
    splce_pkg::t_kind                    r_out_kind;
    splce_pkg::t_entry                   r_out_data;
    logic                                r_out_last;

    logic                                w_accept;
    logic                                w_full;
    logic                                w_load_ok;
    logic [splce_pkg::CNT_W-1:0]         w_idx_m1;
    logic [splce_pkg::IDX_W-1:0]         w_raddr;
    splce_pkg::t_entry                   w_rd;
    splce_pkg::t_entry                   w_in;
    logic                                w_before;
    logic                                w_match;
    logic                                w_we;
    logic [splce_pkg::IDX_W-1:0]         w_waddr;
    splce_pkg::t_entry                   w_wdata;
    logic                                w_out_load;
    logic                                w_out_last;
    splce_pkg::t_kind                    w_out_kind;
    splce_pkg::t_entry                   w_out_data;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_full    = (r_count == splce_pkg::CNT_W'(splce_pkg::TABLE_DEPTH));
    assign w_load_ok = !r_out_valid || i_out_ready;
    assign w_idx_m1  = r_idx - splce_pkg::CNT_W'(1);
    assign w_raddr   = (r_state == splce_pkg::ST_INS) ? w_idx_m1[splce_pkg::IDX_W-1:0]
                                                      : r_idx[splce_pkg::IDX_W-1:0];
    assign w_rd      = r_mem[w_raddr];
    assign w_before  = splce_pkg::goes_before(r_res, w_rd);
    assign w_match   = (w_rd.city == r_key);

    always_comb begin
        w_in.id    = i_parcel_id;
        w_in.city  = i_city_code;
        w_in.zone  = i_zone_code;
        w_in.night = i_overnight;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            splce_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == splce_pkg::CMD_EXTRACT) begin
                        n_state = splce_pkg::ST_EXT;
                    end else if (w_full) begin
                        n_state = splce_pkg::ST_FIN;
                    end else begin
                        n_state = splce_pkg::ST_INS;
                    end
                end
            end
            splce_pkg::ST_INS: begin
                if (r_idx == '0 || !w_before) begin
                    n_state = splce_pkg::ST_FIN;
                end
            end
            splce_pkg::ST_EXT: begin
                if (r_idx == r_count) begin
                    n_state = splce_pkg::ST_FIN;
                end
            end
            splce_pkg::ST_FIN: begin
                if (w_load_ok) begin
                    n_state = splce_pkg::ST_IDLE;
                end
            end
            default: n_state = splce_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_in_ready = (r_state == splce_pkg::ST_IDLE);
        n_count    = r_count;
        n_idx      = r_idx;
        n_keep     = r_keep;
        n_key      = r_key;
        n_res      = r_res;
        n_kind     = r_kind;
        n_pend     = r_pend;
        w_we       = 1'b0;
        w_waddr    = r_idx[splce_pkg::IDX_W-1:0];
        w_wdata    = r_res;
        w_out_load = 1'b0;
        w_out_last = 1'b0;
        w_out_kind = r_kind;
        w_out_data = r_res;
        unique case (r_state)
            splce_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res  = w_in;
                    n_key  = i_city_code;
                    n_pend = 1'b0;
                    n_keep = '0;
                    if (i_cmd == splce_pkg::CMD_EXTRACT) begin
                        n_idx  = '0;
                        n_kind = splce_pkg::KIND_NONE;
                    end else begin
                        n_idx  = r_count;
                        n_kind = w_full ? splce_pkg::KIND_FULL : splce_pkg::KIND_INSERTED;
                    end
                end
            end
            splce_pkg::ST_INS: begin
                w_we = 1'b1;
                if (r_idx != '0 && w_before) begin
                    w_wdata = w_rd;
                    n_idx   = w_idx_m1;
                end else begin
                    w_wdata = r_res;
                    n_count = r_count + splce_pkg::CNT_W'(1);
                end
            end
            splce_pkg::ST_EXT: begin
                if (r_idx != r_count) begin
                    if (w_match) begin
                        if (!r_pend || w_load_ok) begin
                            w_out_load = r_pend;
                            w_out_kind = splce_pkg::KIND_EXTRACTED;
                            n_res      = w_rd;
                            n_pend     = 1'b1;
                            n_kind     = splce_pkg::KIND_EXTRACTED;
                            n_idx      = r_idx + splce_pkg::CNT_W'(1);
                        end
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_keep[splce_pkg::IDX_W-1:0];
                        w_wdata = w_rd;
                        n_keep  = r_keep + splce_pkg::CNT_W'(1);
                        n_idx   = r_idx + splce_pkg::CNT_W'(1);
                    end
                end else begin
                    n_count = r_keep;
                    if (!r_pend) begin
                        n_res.id    = '0;
                        n_res.city  = r_key;
                        n_res.zone  = '0;
                        n_res.night = 1'b0;
                        n_kind      = splce_pkg::KIND_NONE;
                    end
                end
            end
            splce_pkg::ST_FIN: begin
                w_out_load = w_load_ok;
                w_out_last = 1'b1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= splce_pkg::ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_keep <= n_keep;
        r_key  <= n_key;
        r_res  <= n_res;
        r_kind <= n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= w_out_kind;
            r_out_data <= w_out_data;
            r_out_last <= w_out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_out_id        = r_out_data.id;
    assign o_out_city      = r_out_data.city;
    assign o_out_zone      = r_out_data.zone;
    assign o_out_overnight = r_out_data.night;
    assign o_last          = r_out_last;

    `SPLCE_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= splce_pkg::CNT_W'(splce_pkg::TABLE_DEPTH))
    `SPLCE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_in_ready)
    `SPLCE_ASSERT_NEXT(a_fin_loads_last, i_clk, i_rst_n,
        r_state == splce_pkg::ST_FIN && w_load_ok, o_out_valid && o_last)
    `SPLCE_ASSERT_NEXT(a_full_keeps_count, i_clk, i_rst_n,
        w_accept && i_cmd == splce_pkg::CMD_INSERT && w_full,
        r_count == $past(r_count))
    `SPLCE_ASSERT(a_keep_behind_idx, i_clk, i_rst_n,
        r_state == splce_pkg::ST_EXT |-> r_keep <= r_idx)

endmodule

`default_nettype wire
